// ----- rtl/usv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usv_pkg
// Shared types, character codes and host checks for the URL syntax validator.
// ----------------------------------------------------------------------------
package usv_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned ROLE_W     = 3;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned PORT_W     = 16;
    localparam int unsigned PORT_ACC_W = 17;
    localparam int unsigned OCTET_W    = 9;
    localparam int unsigned OUT_DATA_W = 24;

    // byte roles
    localparam logic [ROLE_W-1:0] ROLE_SCHEME = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_SEP    = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_HOST   = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_BRKT   = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_PCOLON = 3'd4;
    localparam logic [ROLE_W-1:0] ROLE_PDIGIT = 3'd5;
    localparam logic [ROLE_W-1:0] ROLE_PATH   = 3'd6;
    localparam logic [ROLE_W-1:0] ROLE_ERROR  = 3'd7;

    // host kinds
    localparam logic [KIND_W-1:0] KIND_REGNAME = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IPV4    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd2;

    // characters the parser looks for
    localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3a;
    localparam logic [BYTE_W-1:0] CH_SLASH   = 8'h2f;
    localparam logic [BYTE_W-1:0] CH_LBRKT   = 8'h5b;
    localparam logic [BYTE_W-1:0] CH_RBRKT   = 8'h5d;
    localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CH_DOT     = 8'h2e;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;

    localparam logic [OCTET_W-1:0]    OCTET_MAX     = 9'd255;
    localparam logic [2:0]            OCTET_DIG_MAX = 3'd3;
    localparam logic [2:0]            OCTETS_NEED   = 3'd4;
    localparam logic [PORT_ACC_W-1:0] PORT_SAT      = 17'd65536;
    localparam logic [PORT_W-1:0]     PORT_MAX      = 16'hffff;

    typedef enum logic [11:0] {
        PH_SCHEME_FIRST = 12'h001,
        PH_SCHEME       = 12'h002,
        PH_SLASH1       = 12'h004,
        PH_SLASH2       = 12'h008,
        PH_HOST_FIRST   = 12'h010,
        PH_HOST         = 12'h020,
        PH_LITERAL      = 12'h040,
        PH_AFTER_LIT    = 12'h080,
        PH_PORT_FIRST   = 12'h100,
        PH_PORT         = 12'h200,
        PH_PATH         = 12'h400,
        PH_ERROR        = 12'h800
    } phase_t;

    typedef struct packed {
        logic       alpha;
        logic       digit;
        logic       alnum;
        logic       hex;
        logic       unreserved;
        logic       sub_delim;
        logic       scheme_ok;
        logic       literal_ok;
        logic       path_ok;
        logic [3:0] digit_val;
    } char_class_t;

    typedef struct packed {
        phase_t                phase;
        logic                  failed;
        logic [1:0]            escape_left;
        logic                  host_nonempty;
        logic                  only_digits_dots;
        logic                  saw_dot;
        logic                  regname_ok;
        logic                  literal_ok;
        logic                  ipv4_ok;
        logic [OCTET_W-1:0]    octet_value;
        logic [2:0]            octet_digits;
        logic                  octet_lead_zero;
        logic [2:0]            octet_count;
        logic [PORT_ACC_W-1:0] port_acc;
        logic                  port_seen;
        logic                  bracketed;
    } parse_state_t;

    typedef struct packed {
        logic [ROLE_W-1:0] role;
        logic              url_ok;
        logic [KIND_W-1:0] host_kind;
        logic              port_given;
        logic [PORT_W-1:0] port_number;
    } result_t;

    localparam parse_state_t ST_RESET = '{
        phase:            PH_SCHEME_FIRST,
        failed:           1'b0,
        escape_left:      2'd0,
        host_nonempty:    1'b0,
        only_digits_dots: 1'b1,
        saw_dot:          1'b0,
        regname_ok:       1'b1,
        literal_ok:       1'b1,
        ipv4_ok:          1'b1,
        octet_value:      '0,
        octet_digits:     3'd0,
        octet_lead_zero:  1'b0,
        octet_count:      3'd0,
        port_acc:         '0,
        port_seen:        1'b0,
        bracketed:        1'b0
    };

    // plain host made of digits and dots with at least one dot
    function automatic logic is_candidate(input parse_state_t s);
        return !s.bracketed && s.host_nonempty && s.only_digits_dots && s.saw_dot;
    endfunction

    function automatic logic host_close_ok(input parse_state_t s);
        logic ok;
        if (!s.host_nonempty || (s.escape_left != 2'd0))
            ok = 1'b0;
        else if (is_candidate(s))
            ok = s.ipv4_ok && (s.octet_digits != 3'd0)
                 && (s.octet_count == (OCTETS_NEED - 3'd1));
        else
            ok = s.regname_ok;
        return ok;
    endfunction

endpackage

// ----- rtl/usv_char_class.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usv_char_class
// Classifies one byte into the character sets used by the parser.
// ----------------------------------------------------------------------------
module usv_char_class
    import usv_pkg::*;
(
    input  logic [BYTE_W-1:0] char_byte,
    output char_class_t       cls
);

    logic is_lower;
    logic is_upper;
    logic is_num;
    logic is_sub;
    logic is_unres;

    always_comb
    begin
        is_lower = (char_byte >= 8'h61) && (char_byte <= 8'h7a);
        is_upper = (char_byte >= 8'h41) && (char_byte <= 8'h5a);
        is_num   = (char_byte >= 8'h30) && (char_byte <= 8'h39);
        // ! $ & ' ( ) * + , ; =
        is_sub   = (char_byte == 8'h21) || (char_byte == 8'h24) || (char_byte == 8'h26)
                || (char_byte == 8'h27) || (char_byte == 8'h28) || (char_byte == 8'h29)
                || (char_byte == 8'h2a) || (char_byte == 8'h2b) || (char_byte == 8'h2c)
                || (char_byte == 8'h3b) || (char_byte == 8'h3d);
        // alnum - . _ ~
        is_unres = is_lower || is_upper || is_num || (char_byte == 8'h2d)
                || (char_byte == 8'h2e) || (char_byte == 8'h5f) || (char_byte == 8'h7e);

        cls.alpha      = is_lower || is_upper;
        cls.digit      = is_num;
        cls.alnum      = is_lower || is_upper || is_num;
        cls.hex        = is_num || ((char_byte >= 8'h61) && (char_byte <= 8'h66))
                      || ((char_byte >= 8'h41) && (char_byte <= 8'h46));
        cls.unreserved = is_unres;
        cls.sub_delim  = is_sub;
        cls.scheme_ok  = cls.alnum || (char_byte == 8'h2b) || (char_byte == 8'h2d)
                      || (char_byte == 8'h2e);
        cls.literal_ok = is_unres || is_sub || (char_byte == CH_COLON);
        // pchar plus / ? #
        cls.path_ok    = is_unres || is_sub || (char_byte == CH_SLASH) || (char_byte == 8'h3f)
                      || (char_byte == 8'h23) || (char_byte == CH_COLON) || (char_byte == 8'h40);
        cls.digit_val  = char_byte[3:0];
    end

endmodule

// ----- rtl/usv_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usv_parser
// Phase machine and host/port trackers; one byte per enabled cycle.
// ----------------------------------------------------------------------------
module usv_parser
    import usv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [BYTE_W-1:0] char_byte,
    input  logic              final_byte,
    input  char_class_t       cls,
    output result_t           res
);

    parse_state_t st_reg;
    parse_state_t st_next;
    parse_state_t nx;
    logic         fail;
    logic         host_en;
    logic [11:0]  oct_prod;
    logic [19:0]  port_prod;
    logic         fin_ok;

    always_comb
    begin
        nx        = st_reg;
        res       = '0;
        res.role  = ROLE_ERROR;
        fail      = 1'b0;
        host_en   = 1'b0;
        oct_prod  = ({3'b0, st_reg.octet_value} << 3) + ({3'b0, st_reg.octet_value} << 1)
                  + {8'b0, cls.digit_val};
        port_prod = ({3'b0, st_reg.port_acc} << 3) + ({3'b0, st_reg.port_acc} << 1)
                  + {16'b0, cls.digit_val};
        fin_ok    = 1'b0;

        unique case (st_reg.phase)
            PH_SCHEME_FIRST:
            begin
                res.role = ROLE_SCHEME;
                if (cls.alpha)
                    nx.phase = PH_SCHEME;
                else
                    fail = 1'b1;
            end
            PH_SCHEME:
            begin
                if (char_byte == CH_COLON)
                begin
                    res.role = ROLE_SEP;
                    nx.phase = PH_SLASH1;
                end
                else
                begin
                    res.role = ROLE_SCHEME;
                    if (!cls.scheme_ok)
                        fail = 1'b1;
                end
            end
            PH_SLASH1, PH_SLASH2:
            begin
                res.role = ROLE_SEP;
                if (char_byte != CH_SLASH)
                    fail = 1'b1;
                else
                    nx.phase = (st_reg.phase == PH_SLASH1) ? PH_SLASH2 : PH_HOST_FIRST;
            end
            PH_HOST_FIRST:
            begin
                if (char_byte == CH_LBRKT)
                begin
                    res.role     = ROLE_BRKT;
                    nx.bracketed = 1'b1;
                    nx.phase     = PH_LITERAL;
                end
                else
                begin
                    res.role = ROLE_HOST;
                    if ((char_byte == CH_RBRKT) || (char_byte == CH_COLON)
                        || (char_byte == CH_SLASH))
                        fail = 1'b1;
                    else
                    begin
                        host_en  = 1'b1;
                        nx.phase = PH_HOST;
                    end
                end
            end
            PH_HOST:
            begin
                if (st_reg.escape_left != 2'd0)
                begin
                    res.role = ROLE_HOST;
                    if (cls.hex)
                        nx.escape_left = st_reg.escape_left - 2'd1;
                    else
                        fail = 1'b1;
                end
                else if (char_byte == CH_COLON)
                begin
                    res.role = ROLE_PCOLON;
                    if (host_close_ok(st_reg))
                    begin
                        nx.port_seen = 1'b1;
                        nx.phase     = PH_PORT_FIRST;
                    end
                    else
                        fail = 1'b1;
                end
                else if (char_byte == CH_SLASH)
                begin
                    res.role = ROLE_PATH;
                    if (host_close_ok(st_reg))
                        nx.phase = PH_PATH;
                    else
                        fail = 1'b1;
                end
                else
                begin
                    res.role = ROLE_HOST;
                    if ((char_byte == CH_LBRKT) || (char_byte == CH_RBRKT))
                        fail = 1'b1;
                    else
                        host_en = 1'b1;
                end
            end
            PH_LITERAL:
            begin
                if (st_reg.escape_left != 2'd0)
                begin
                    res.role = ROLE_HOST;
                    if (cls.hex)
                        nx.escape_left = st_reg.escape_left - 2'd1;
                    else
                        fail = 1'b1;
                end
                else if (char_byte == CH_RBRKT)
                begin
                    res.role = ROLE_BRKT;
                    if (st_reg.host_nonempty && st_reg.literal_ok)
                        nx.phase = PH_AFTER_LIT;
                    else
                        fail = 1'b1;
                end
                else
                begin
                    res.role = ROLE_HOST;
                    if ((char_byte == CH_LBRKT) || (char_byte == CH_SLASH))
                        fail = 1'b1;
                    else
                    begin
                        nx.host_nonempty = 1'b1;
                        if (char_byte == CH_PERCENT)
                            nx.escape_left = 2'd2;
                        else if (!cls.literal_ok)
                            nx.literal_ok = 1'b0;
                    end
                end
            end
            PH_AFTER_LIT:
            begin
                if (char_byte == CH_COLON)
                begin
                    res.role     = ROLE_PCOLON;
                    nx.port_seen = 1'b1;
                    nx.phase     = PH_PORT_FIRST;
                end
                else if (char_byte == CH_SLASH)
                begin
                    res.role = ROLE_PATH;
                    nx.phase = PH_PATH;
                end
                else
                    fail = 1'b1;
            end
            PH_PORT_FIRST, PH_PORT:
            begin
                if (cls.digit)
                begin
                    res.role = ROLE_PDIGIT;
                    if (port_prod >= {3'b0, PORT_SAT})
                    begin
                        nx.port_acc = PORT_SAT;
                        fail        = 1'b1;
                    end
                    else
                    begin
                        nx.port_acc = port_prod[PORT_ACC_W-1:0];
                        nx.phase    = PH_PORT;
                    end
                end
                else if ((char_byte == CH_SLASH) && (st_reg.phase == PH_PORT))
                begin
                    res.role = ROLE_PATH;
                    nx.phase = PH_PATH;
                end
                else
                begin
                    res.role = ROLE_PDIGIT;
                    fail     = 1'b1;
                end
            end
            PH_PATH:
            begin
                res.role = ROLE_PATH;
                if (st_reg.escape_left != 2'd0)
                begin
                    if (cls.hex)
                        nx.escape_left = st_reg.escape_left - 2'd1;
                    else
                        fail = 1'b1;
                end
                else if (char_byte == CH_PERCENT)
                    nx.escape_left = 2'd2;
                else if (!cls.path_ok)
                    fail = 1'b1;
            end
            default:
                fail = 1'b1;
        endcase

        // one byte of a plain host
        if (host_en)
        begin
            nx.host_nonempty = 1'b1;
            if (char_byte == CH_PERCENT)
            begin
                nx.escape_left      = 2'd2;
                nx.only_digits_dots = 1'b0;
            end
            else
            begin
                if (char_byte == CH_DOT)
                begin
                    nx.saw_dot = 1'b1;
                    if ((st_reg.octet_digits == 3'd0)
                        || (st_reg.octet_count >= (OCTETS_NEED - 3'd1)))
                        nx.ipv4_ok = 1'b0;
                    if (st_reg.octet_count < OCTETS_NEED)
                        nx.octet_count = st_reg.octet_count + 3'd1;
                    nx.octet_value     = '0;
                    nx.octet_digits    = 3'd0;
                    nx.octet_lead_zero = 1'b0;
                end
                else if (cls.digit)
                begin
                    if ((st_reg.octet_digits >= OCTET_DIG_MAX)
                        || ((st_reg.octet_digits >= 3'd1) && st_reg.octet_lead_zero))
                        nx.ipv4_ok = 1'b0;
                    if ((st_reg.octet_digits == 3'd0) && (char_byte == CH_ZERO))
                        nx.octet_lead_zero = 1'b1;
                    if (oct_prod > {3'b0, OCTET_MAX})
                    begin
                        nx.ipv4_ok     = 1'b0;
                        nx.octet_value = OCTET_MAX + 9'd1;
                    end
                    else
                        nx.octet_value = oct_prod[OCTET_W-1:0];
                    if (st_reg.octet_digits < (OCTET_DIG_MAX + 3'd1))
                        nx.octet_digits = st_reg.octet_digits + 3'd1;
                end
                else
                    nx.only_digits_dots = 1'b0;
                if (!(cls.unreserved || cls.sub_delim))
                    nx.regname_ok = 1'b0;
            end
        end

        if (fail)
        begin
            nx.failed      = 1'b1;
            nx.phase       = PH_ERROR;
            nx.escape_left = 2'd0;
        end

        if (nx.failed)
            res.role = ROLE_ERROR;

        // verdict and summary on the last byte, then back to reset state
        st_next = nx;
        if (final_byte)
        begin
            if (!nx.failed && (nx.escape_left == 2'd0))
            begin
                if (nx.phase == PH_HOST)
                    fin_ok = host_close_ok(nx);
                else
                    fin_ok = (nx.phase == PH_AFTER_LIT) || (nx.phase == PH_PORT)
                          || (nx.phase == PH_PATH);
            end
            res.url_ok      = fin_ok;
            res.host_kind   = nx.bracketed ? KIND_LITERAL
                            : (is_candidate(nx) ? KIND_IPV4 : KIND_REGNAME);
            res.port_given  = nx.port_seen;
            res.port_number = nx.port_acc[PORT_ACC_W-1] ? PORT_MAX
                            : nx.port_acc[PORT_W-1:0];
            st_next         = ST_RESET;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_RESET;
        else if (step_en)
            st_reg <= st_next;
    end

endmodule

// ----- rtl/url_syntax_validator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_syntax_validator
// Streaming checker for URLs of the form scheme://host[:port][/path].
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one URL byte per beat on s_tdata, s_tlast on the final
//   byte of a URL. Master stream: one result beat per input beat, m_tlast
//   copies the input flag. Every beat carries the byte role; on the beat
//   with m_tlast set it also carries the verdict, host kind and port (zero
//   on other beats). The next beat after a last byte starts a new URL.
//   Path: each byte passes the input register, then the result register;
//   the phase machine and all per-byte checks sit in the single
//   combinational step between them.
//   Throughput: one byte per cycle sustained while m_tready is high;
//   a new byte is taken while a finished result waits, as the result
//   register frees as it is taken.
//   Stall: with m_tready low both registers fill and s_tready drops; no
//   beat is lost or repeated.
//   Reset: rst_n clears both valid flags and returns the parser to the
//   start of a scheme, as after a last byte.
// ----------------------------------------------------------------------------
module url_syntax_validator
    import usv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] char_byte
    input  logic                  s_tlast,   // final_byte
    // master stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [2:0] byte_role, [3] url_ok,
                                             // [5:4] host_kind, [6] port_given,
                                             // [22:7] port_number, [23] zero
    output logic                  m_tlast    // is_final
);

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // result register
    logic              out_valid_reg;
    result_t           out_res_reg;
    logic              out_last_reg;

    logic              advance;
    logic              in_take;
    char_class_t       cls;
    result_t           step_res;

    // byte moves to the result register when that is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    usv_char_class u_class
    (
        .char_byte (in_byte_reg),
        .cls       (cls)
    );

    usv_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .char_byte  (in_byte_reg),
        .final_byte (in_last_reg),
        .cls        (cls),
        .res        (step_res)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance)
        begin
            out_res_reg  <= step_res;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_res_reg.port_number, out_res_reg.port_given,
                       out_res_reg.host_kind, out_res_reg.url_ok, out_res_reg.role};

endmodule
